// ===== hw/rtl/smoe_pkg.sv =====
package smoe_pkg;

    // Request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_RUN    = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Operation register codes
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_TRANS = 3'd3,
        OP_SYM   = 3'd4,
        OP_LOWER = 3'd5,
        OP_UPPER = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ELEM     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SYM      = 2'd2,
        ST_NOTSYM   = 2'd3
    } status_t;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_ROWS_A    = 3'd0;
    localparam logic [2:0] REG_COLS_A    = 3'd1;
    localparam logic [2:0] REG_ROWS_B    = 3'd2;
    localparam logic [2:0] REG_COLS_B    = 3'd3;
    localparam logic [2:0] REG_OPERATION = 3'd4;

    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 32;
    localparam int VALUE_W = 35;
    localparam int DREG_W  = 4;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

endpackage

// ===== hw/rtl/smoe_ram.sv =====
module smoe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/small_matrix_operation_engine.sv =====
// Small matrix engine: holds two signed 16-bit matrices A and B of up to
// MAX_DIM x MAX_DIM in two RAMs and runs one configured operation on them.
// A word is accepted when start is high and busy is low. Load words write
// one element and leave busy low, so loads stream at one per clock while
// no run holds busy. A run word that passes its checks raises busy until
// its last result has been driven. A failed dimension check or a symmetry
// test of a non-square A gives one result in the cycle after acceptance; a
// run word with the unused operation is ignored. Sum, difference, transpose
// and the triangular outputs do one RAM read, then one emit per element.
// The product reads, multiplies and adds once per cols_a term, using the
// single multiplier and shared adder. The symmetry test reads A(i,j), then
// A(j,i) on the A store's single read port, and stops at the first mismatch.
// Each result is on the result ports for exactly one cycle with out_valid
// high; the receiver cannot hold it off. The element stores have no reset:
// read only elements that were loaded. Configure only while busy is low.
module small_matrix_operation_engine #(
    parameter int MAX_DIM = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // command side
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             req_type,
    input  logic [2:0]                             row_index,
    input  logic [2:0]                             col_index,
    input  logic signed [smoe_pkg::ELEM_W-1:0]     element_value,
    // result side
    output logic                                   out_valid,
    output logic [2:0]                             out_row,
    output logic [2:0]                             out_col,
    output logic signed [smoe_pkg::VALUE_W-1:0]    out_value,
    output logic [1:0]                             status,
    output logic                                   last_result,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [smoe_pkg::PADDR_W-1:0]           paddr,
    input  logic [smoe_pkg::PDATA_W-1:0]           pwdata,
    output logic [smoe_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    import smoe_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EL_RD   = 9'b000000010,
        S_EL_OUT  = 9'b000000100,
        S_MUL_RD  = 9'b000001000,
        S_MUL_MUL = 9'b000010000,
        S_MUL_ACC = 9'b000100000,
        S_SYM_RD1 = 9'b001000000,
        S_SYM_RD2 = 9'b010000000,
        S_SYM_CMP = 9'b100000000
    } state_t;

    // ---------------- configuration registers ----------------
    logic [DREG_W-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [2:0]        operation_reg;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DREG_W'(8);
            cols_a_reg    <= DREG_W'(8);
            rows_b_reg    <= DREG_W'(8);
            cols_b_reg    <= DREG_W'(8);
            operation_reg <= OP_ADD;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ROWS_A:    rows_a_reg    <= pwdata[DREG_W-1:0];
                REG_COLS_A:    cols_a_reg    <= pwdata[DREG_W-1:0];
                REG_ROWS_B:    rows_b_reg    <= pwdata[DREG_W-1:0];
                REG_COLS_B:    cols_b_reg    <= pwdata[DREG_W-1:0];
                REG_OPERATION: operation_reg <= pwdata[2:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ROWS_A:    prdata = PDATA_W'(rows_a_reg);
            REG_COLS_A:    prdata = PDATA_W'(cols_a_reg);
            REG_ROWS_B:    prdata = PDATA_W'(rows_b_reg);
            REG_COLS_B:    prdata = PDATA_W'(cols_b_reg);
            REG_OPERATION: prdata = PDATA_W'(operation_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- helpers ----------------
    // Out-of-range dimensions: zero acts as one, too large acts as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DREG_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (32'(r) > MAX_DIM)
            d = DIM_W'(MAX_DIM);
        else
            d = r[DIM_W-1:0];
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

    function automatic logic signed [VALUE_W-1:0] sx_elem(input logic [ELEM_W-1:0] v);
        return {{(VALUE_W-ELEM_W){v[ELEM_W-1]}}, v};
    endfunction

    // ---------------- element stores ----------------
    logic              a_we, b_we;
    logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
    logic [ELEM_W-1:0] a_rdata, b_rdata;
    logic              load_ok;
    logic              accept;

    assign accept  = start && !busy;
    assign load_ok = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
    assign wr_addr = addr_of(row_index[IDX_W-1:0], col_index[IDX_W-1:0]);
    assign a_we    = accept && (req_type == REQ_LOAD_A) && load_ok;
    assign b_we    = accept && (req_type == REQ_LOAD_B) && load_ok;

    smoe_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (element_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    smoe_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (element_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // ---------------- sequencer state ----------------
    state_t                    state_reg, state_next;
    logic [2:0]                op_reg, op_next;
    logic [IDX_W-1:0]          i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [IDX_W-1:0]          ilast_reg, ilast_next, jlast_reg, jlast_next;
    logic [IDX_W-1:0]          mlast_reg, mlast_next;
    logic signed [VALUE_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [ELEM_W-1:0]         hold_reg, hold_next;

    logic                      ov_reg, ov_next;
    logic [2:0]                row_reg, row_next, col_reg, col_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [1:0]                st_reg, st_next;
    logic                      last_reg, last_next;

    // Run-time dimensions from the registers
    logic [DIM_W-1:0] ra, ca, rb, cb;
    assign ra = clamp_dim(rows_a_reg);
    assign ca = clamp_dim(cols_a_reg);
    assign rb = clamp_dim(rows_b_reg);
    assign cb = clamp_dim(cols_b_reg);

    // Shared adder: element sum/difference and product accumulation
    logic signed [VALUE_W-1:0] alu_x, alu_y, alu_sum;
    logic                      alu_sub;
    assign alu_sum = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

    // Row-major walk over the result grid
    logic             at_last;
    logic [IDX_W-1:0] i_step, j_step;
    assign at_last = (i_reg == ilast_reg) && (j_reg == jlast_reg);
    always_comb
    begin
        if (j_reg == jlast_reg)
        begin
            j_step = '0;
            i_step = i_reg + IDX_W'(1);
        end
        else
        begin
            j_step = j_reg + IDX_W'(1);
            i_step = i_reg;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Read addresses follow the state
    always_comb
    begin
        a_raddr = addr_of(i_reg, j_reg);
        b_raddr = addr_of(i_reg, j_reg);
        case (state_reg)
            S_EL_RD:
            begin
                if (op_reg == OP_TRANS)
                    a_raddr = addr_of(j_reg, i_reg);
            end
            S_MUL_RD:
            begin
                a_raddr = addr_of(i_reg, m_reg);
                b_raddr = addr_of(m_reg, j_reg);
            end
            S_SYM_RD2:
            begin
                a_raddr = addr_of(j_reg, i_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        ilast_next = ilast_reg;
        jlast_next = jlast_reg;
        mlast_next = mlast_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        hold_next  = hold_reg;
        ov_next    = 1'b0;
        row_next   = row_reg;
        col_next   = col_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        last_next  = last_reg;
        alu_x      = sx_elem(a_rdata);
        alu_y      = sx_elem(b_rdata);
        alu_sub    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_RUN) && (operation_reg != OP_NONE))
                begin
                    op_next    = operation_reg;
                    i_next     = '0;
                    j_next     = '0;
                    m_next     = '0;
                    acc_next   = '0;
                    ilast_next = IDX_W'(ra - DIM_W'(1));
                    jlast_next = IDX_W'(ca - DIM_W'(1));
                    mlast_next = IDX_W'(ca - DIM_W'(1));
                    row_next   = '0;
                    col_next   = '0;
                    val_next   = '0;
                    if (operation_reg == OP_SYM)
                    begin
                        if (ra != ca)
                        begin
                            // Non-square A is never symmetric
                            ov_next   = 1'b1;
                            st_next   = ST_NOTSYM;
                            last_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SYM_RD1;
                        end
                    end
                    else if ((((operation_reg == OP_ADD) || (operation_reg == OP_SUB))
                              && ((ra != rb) || (ca != cb)))
                             || ((operation_reg == OP_MUL) && (ca != rb)))
                    begin
                        ov_next   = 1'b1;
                        st_next   = ST_MISMATCH;
                        last_next = 1'b1;
                    end
                    else if (operation_reg == OP_MUL)
                    begin
                        jlast_next = IDX_W'(cb - DIM_W'(1));
                        state_next = S_MUL_RD;
                    end
                    else
                    begin
                        if (operation_reg == OP_TRANS)
                        begin
                            ilast_next = IDX_W'(ca - DIM_W'(1));
                            jlast_next = IDX_W'(ra - DIM_W'(1));
                        end
                        state_next = S_EL_RD;
                    end
                end
            end

            S_EL_RD:
            begin
                state_next = S_EL_OUT;
            end

            S_EL_OUT:
            begin
                alu_sub  = (op_reg == OP_SUB);
                ov_next  = 1'b1;
                row_next = 3'(i_reg);
                col_next = 3'(j_reg);
                st_next  = ST_ELEM;
                last_next = at_last;
                case (op_reg)
                    OP_ADD, OP_SUB: val_next = alu_sum;
                    OP_TRANS:       val_next = sx_elem(a_rdata);
                    OP_LOWER:       val_next = (i_reg >= j_reg) ? sx_elem(a_rdata) : '0;
                    OP_UPPER:       val_next = (i_reg <= j_reg) ? sx_elem(a_rdata) : '0;
                    default:        val_next = '0;
                endcase
                if (at_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_step;
                    j_next     = j_step;
                    state_next = S_EL_RD;
                end
            end

            S_MUL_RD:
            begin
                state_next = S_MUL_MUL;
            end

            S_MUL_MUL:
            begin
                prod_next  = signed'(a_rdata) * signed'(b_rdata);
                state_next = S_MUL_ACC;
            end

            S_MUL_ACC:
            begin
                alu_x = acc_reg;
                alu_y = VALUE_W'(prod_reg);
                if (m_reg == mlast_reg)
                begin
                    ov_next   = 1'b1;
                    row_next  = 3'(i_reg);
                    col_next  = 3'(j_reg);
                    val_next  = alu_sum;
                    st_next   = ST_ELEM;
                    last_next = at_last;
                    acc_next  = '0;
                    m_next    = '0;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_step;
                        j_next     = j_step;
                        state_next = S_MUL_RD;
                    end
                end
                else
                begin
                    acc_next   = alu_sum;
                    m_next     = m_reg + IDX_W'(1);
                    state_next = S_MUL_RD;
                end
            end

            S_SYM_RD1:
            begin
                state_next = S_SYM_RD2;
            end

            S_SYM_RD2:
            begin
                // Hold A(i,j) while A(j,i) is read
                hold_next  = a_rdata;
                state_next = S_SYM_CMP;
            end

            S_SYM_CMP:
            begin
                if (hold_reg != a_rdata)
                begin
                    ov_next    = 1'b1;
                    st_next    = ST_NOTSYM;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (at_last)
                begin
                    ov_next    = 1'b1;
                    st_next    = ST_SYM;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_step;
                    j_next     = j_step;
                    state_next = S_SYM_RD1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        m_reg     <= m_next;
        ilast_reg <= ilast_next;
        jlast_reg <= jlast_next;
        mlast_reg <= mlast_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        hold_reg  <= hold_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        val_reg   <= val_next;
        st_reg    <= st_next;
        last_reg  <= last_next;
    end

    assign out_valid   = ov_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign out_value   = val_reg;
    assign status      = st_reg;
    assign last_result = last_reg;

    // ---------------- assertions ----------------
    // The final word of a run always frees the engine
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> !busy)
        else $error("last result driven while run still active");

    // More words follow a non-final word
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> busy)
        else $error("non-final result with engine idle");

    // Error and symmetry verdicts are single-word runs
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_ELEM) |-> last_result)
        else $error("status word not marked last");

    // A load never starts a run
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((req_type == REQ_LOAD_A) || (req_type == REQ_LOAD_B))
        |=> !busy && !out_valid)
        else $error("load word caused activity");

endmodule
